### design/mtpb_pkg.sv
// Package for the masked translucent pixel blend block.
// Holds the blend weight type, the byte constants and the percent-to-alpha function.
// No dependencies.
package mtpb_pkg;

  // Pixel layout and the fixed-point scale of the global alpha.
  localparam int unsigned LANES     = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ALPHA_W   = 9;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned SUM_W     = 17;

  localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [BYTE_W-1:0]  MASK_SKIP = 8'h00;
  localparam logic [BYTE_W-1:0]  MASK_FULL = 8'hff;
  localparam logic [BYTE_W-1:0]  BYTE_MAX  = 8'hff;

  // floor(p * 256 / 100) equals (p * 41944) >> 14 for every p in 0..100.
  localparam logic [15:0] ALPHA_RECIP = 16'd41944;
  localparam int unsigned ALPHA_SHIFT = 14;

  // Weights that every byte lane applies to the source and the destination byte.
  typedef struct packed {
    logic               skip;
    logic [ALPHA_W-1:0] src_weight;
    logic [ALPHA_W-1:0] dst_weight;
  } weight_t;

  // Global alpha from the percent register, with the percent clamped to 100.
  function automatic logic [ALPHA_W-1:0] alpha_of(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] pct_clamped;
    logic [22:0]      prod;
    pct_clamped = (pct > PCT_MAX) ? PCT_MAX : pct;
    prod        = 23'(pct_clamped) * 23'(ALPHA_RECIP);
    return prod[ALPHA_SHIFT +: ALPHA_W];
  endfunction

endpackage

### design/masked_translucent_pixel_blend.sv
// Top level of the masked translucent pixel blend block.
// Three-stage pipeline: weight stage, four byte lanes, merged output register.
// Depends on mtpb_pkg, mtpb_weight and mtpb_lane.
//
//   channel   signals                                        direction
//   in        in_valid, in_ready, src_pixel, dst_pixel,       into the block
//             mask_level
//   out       out_valid, out_ready, out_pixel, write_enable   out of the block
//   cfg       cfg_write_en, cfg_write_data (trans_percent)    into the block
//
// One item enters per cycle while the output is not stalled; each result passes weight1, pix2 and the output register.
// The weight multiply, the lane multiply-adds and the output register form the stages.
// Synchronous reset empties the pipeline and sets the percent to 100.
// A stall at the output holds a full stage only when every stage after it is full; other stages still move on and fill.
module masked_translucent_pixel_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [6:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  input  logic [7:0]  mask_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic        write_enable
);

  localparam int unsigned BW = mtpb_pkg::BYTE_W;

  logic [mtpb_pkg::ALPHA_W-1:0] alpha;
  logic                         pct_zero;

  logic                         en1, en2, en3;
  logic                         v1, v2;
  mtpb_pkg::weight_t            weight_in;
  mtpb_pkg::weight_t            weight1;
  logic [31:0]                  src1, dst1;
  logic [31:0]                  lane_pix;
  logic [31:0]                  pix2;
  logic                         skip2;

  // Percent register kept as its alpha and a zero flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= mtpb_pkg::ALPHA_ONE;
      pct_zero <= 1'b0;
    end else if (cfg_write_en) begin
      alpha    <= mtpb_pkg::alpha_of(cfg_write_data);
      pct_zero <= (cfg_write_data == '0);
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  // Stage one: blend weights.
  mtpb_weight u_weight (
    .alpha      (alpha),
    .pct_zero   (pct_zero),
    .mask_level (mask_level),
    .weight     (weight_in)
  );

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      weight1 <= weight_in;
      src1    <= src_pixel;
      dst1    <= dst_pixel;
    end
  end

  // Stage two: one lane per byte.
  for (genvar k = 0; k < mtpb_pkg::LANES; k++) begin : g_lane
    mtpb_lane u_lane (
      .src_byte   (src1[k*BW +: BW]),
      .dst_byte   (dst1[k*BW +: BW]),
      .weight     (weight1),
      .blend_byte (lane_pix[k*BW +: BW])
    );
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      pix2  <= lane_pix;
      skip2 <= weight1.skip;
    end
  end

  // Stage three: merge the lanes; a skipped pixel shows zero and no write.
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_pixel    <= skip2 ? '0 : pix2;
      write_enable <= !skip2;
    end
  end

endmodule

### design/mtpb_weight.sv
// Weight stage of the masked translucent pixel blend block.
// Turns the global alpha and the mask byte into source and destination weights.
// Depends on mtpb_pkg.
module mtpb_weight (
  input  logic [mtpb_pkg::ALPHA_W-1:0] alpha,
  input  logic                         pct_zero,
  input  logic [mtpb_pkg::BYTE_W-1:0]  mask_level,
  output mtpb_pkg::weight_t            weight
);

  logic [16:0]                  mask_prod;
  logic [mtpb_pkg::BYTE_W-1:0]  alpha_scaled;

  // Scaled alpha for a partial mask; m * a stays below 65536 for m up to 254.
  assign mask_prod    = 17'(mask_level) * 17'(alpha);
  assign alpha_scaled = mask_prod[15:8];

  // A full mask uses the global alpha against 256, any other mask works against 255.
  always_comb begin
    weight.skip = pct_zero || (mask_level == mtpb_pkg::MASK_SKIP);
    if (mask_level == mtpb_pkg::MASK_FULL) begin
      weight.src_weight = alpha;
      weight.dst_weight = mtpb_pkg::ALPHA_ONE - alpha;
    end else begin
      weight.src_weight = {1'b0, alpha_scaled};
      weight.dst_weight = {1'b0, mtpb_pkg::BYTE_MAX - alpha_scaled};
    end
  end

endmodule

### design/mtpb_lane.sv
// One byte lane of the masked translucent pixel blend block.
// Mixes one source byte and one destination byte under the given weights.
// Depends on mtpb_pkg.
module mtpb_lane (
  input  logic [mtpb_pkg::BYTE_W-1:0] src_byte,
  input  logic [mtpb_pkg::BYTE_W-1:0] dst_byte,
  input  mtpb_pkg::weight_t           weight,
  output logic [mtpb_pkg::BYTE_W-1:0] blend_byte
);

  logic [mtpb_pkg::SUM_W-1:0] sum;

  // Weighted sum; the weights add to at most 256, so bits 15:8 never exceed 255.
  assign sum = mtpb_pkg::SUM_W'(src_byte) * mtpb_pkg::SUM_W'(weight.src_weight)
             + mtpb_pkg::SUM_W'(dst_byte) * mtpb_pkg::SUM_W'(weight.dst_weight);

  assign blend_byte = sum[15:8];

endmodule

### design/mtpb_checker.sv
// Port checker for the masked translucent pixel blend block.
// Watches the top level's ports only; bound to the top level below.
// Depends on masked_translucent_pixel_blend.
module mtpb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        write_enable
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(write_enable))
    else $error("result changed while stalled");

  // A pixel that is not written carries zero.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> out_pixel == 32'd0)
    else $error("skipped pixel carries data");

  // The input only backs up once the output holds an item.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind masked_translucent_pixel_blend mtpb_checker u_mtpb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_pixel    (out_pixel),
  .write_enable (write_enable)
);
